// ----- rtl/longest_run_without_repeat_assert.svh -----
// Assertion macros used by the checker of the longest run block.
`ifndef LONGEST_RUN_WITHOUT_REPEAT_ASSERT_SVH
`define LONGEST_RUN_WITHOUT_REPEAT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LRWR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrwr assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LRWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrwr assertion failed");

`endif

// ----- rtl/lrwr_pkg.sv -----
// Types and constants of the longest repeat-free run block.
package lrwr_pkg;

   localparam int ID_BITS      = 10;
   localparam int SYM_BITS     = 10;
   localparam int SYMBOL_COUNT = 1 << SYM_BITS;
   localparam int RUN_BITS     = 16;
   localparam int POS_BITS     = 32;

   typedef logic [SYM_BITS-1:0] sym_type;
   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [RUN_BITS-1:0] run_type;

   localparam run_type RUN_MAX = '1;

   typedef struct packed {
      sym_type sym;
      logic    last;
   } item_type;

   typedef struct packed {
      run_type run;
      logic    done;
   } result_type;

endpackage

// ----- rtl/lrwr_pos_ram.sv -----
// Single-write, single-read RAM with registered read data.
module lrwr_pos_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lrwr_window.sv -----
// Window tracking: position counter, window start, best run and write forwarding.
module lrwr_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  lrwr_pkg::item_type     item,
   input  lrwr_pkg::pos_type      rd_pos,
   output lrwr_pkg::pos_type      pos,
   output lrwr_pkg::result_type   result
);

   lrwr_pkg::pos_type count_ff, count_in;
   lrwr_pkg::pos_type start_ff, start_in;
   lrwr_pkg::run_type best_ff, best_in;
   lrwr_pkg::pos_type fwd_pos_ff;
   lrwr_pkg::sym_type fwd_sym_ff;
   logic              fwd_vld_ff;

   lrwr_pkg::pos_type prev;
   lrwr_pkg::pos_type span;
   lrwr_pkg::pos_type start_mid;
   lrwr_pkg::pos_type span_mid;
   logic              moved;
   logic              sat;
   lrwr_pkg::run_type run;
   lrwr_pkg::run_type best_new;

   always_comb begin
      pos = count_ff + lrwr_pkg::pos_type'(1);
      // the RAM read missed the write made in the same cycle it was issued
      prev = (fwd_vld_ff && (fwd_sym_ff == item.sym)) ? fwd_pos_ff : rd_pos;
      span = pos - start_ff;
      moved = (prev != '0) && ((prev - start_ff) < span);
      start_mid = moved ? (prev + lrwr_pkg::pos_type'(1)) : start_ff;
      span_mid = pos - start_mid;
      sat = span_mid >= lrwr_pkg::pos_type'(lrwr_pkg::RUN_MAX);
      run = sat ? lrwr_pkg::RUN_MAX
                : (span_mid[lrwr_pkg::RUN_BITS-1:0] + lrwr_pkg::run_type'(1));
      best_new = (run > best_ff) ? run : best_ff;

      result.run  = best_new;
      result.done = item.last;

      count_in = pos;
      start_in = item.last ? (pos + lrwr_pkg::pos_type'(1)) : start_mid;
      best_in  = item.last ? '0 : best_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         start_ff   <= lrwr_pkg::pos_type'(1);
         best_ff    <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (fire) begin
         count_ff   <= count_in;
         start_ff   <= start_in;
         best_ff    <= best_in;
         fwd_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         fwd_sym_ff <= item.sym;
         fwd_pos_ff <= pos;
      end
   end

endmodule

// ----- rtl/longest_run_without_repeat.sv -----
// Longest repeat-free run per case: one result beat per accepted input beat.
// After reset the block sweeps its 1024-entry position RAM to zero, one entry
// a cycle, and holds req_stall high until the sweep ends. From then on it
// takes one beat every cycle while rsp_stall does not hold the output back. The
// accepting edge registers the beat and the RAM read of the symbol's last
// position; the window update then lands in the output register once the
// output is free. A write made in the cycle a read is issued is forwarded, so
// back-to-back repeats of one symbol cost nothing. Stored positions use a
// free-running 32-bit counter, so a new case starts without touching the RAM.
module longest_run_without_repeat (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lrwr_pkg::ID_BITS-1:0]          req_symbol_id,
   input  logic                                  req_last_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lrwr_pkg::RUN_BITS-1:0]         rsp_longest_run,
   output logic                                  rsp_case_done
);

   logic                 clearing_ff;
   lrwr_pkg::sym_type    clr_addr_ff;
   logic                 s1_vld_ff, s1_vld_in;
   lrwr_pkg::item_type   item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lrwr_pkg::result_type result_ff;

   logic                 accept;
   logic                 s1_fire;
   lrwr_pkg::pos_type    rd_pos;
   lrwr_pkg::pos_type    pos;
   lrwr_pkg::result_type result;
   logic                 wr_en;
   lrwr_pkg::sym_type    wr_addr;
   lrwr_pkg::pos_type    wr_data;

   assign s1_fire   = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_vld_ff && !s1_fire);
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept || (s1_vld_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   assign wr_en   = clearing_ff || s1_fire;
   assign wr_addr = clearing_ff ? clr_addr_ff : item_ff.sym;
   assign wr_data = clearing_ff ? '0 : pos;

   lrwr_pos_ram #(
      .ADDR_BITS (lrwr_pkg::SYM_BITS),
      .DATA_BITS (lrwr_pkg::POS_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (lrwr_pkg::sym_type'(req_symbol_id)),
      .rd_data (rd_pos)
   );

   lrwr_window u_window (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (item_ff),
      .rd_pos (rd_pos),
      .pos    (pos),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // advance the clear sweep and drop out after the last entry
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + lrwr_pkg::sym_type'(1);
            if (clr_addr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.sym  <= lrwr_pkg::sym_type'(req_symbol_id);
         item_ff.last <= req_last_item;
      end
      if (s1_fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = result_ff.run;
   assign rsp_case_done   = result_ff.done;

endmodule

// ----- rtl/lrwr_checker.sv -----
// Port checker for the longest run block and its bind to the top level.
`include "longest_run_without_repeat_assert.svh"

module lrwr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lrwr_pkg::RUN_BITS-1:0] rsp_longest_run,
   input logic                          rsp_case_done
);

   logic                 rsp_take;
   logic                 req_take;
   logic                 prev_vld_ff;
   logic                 prev_done_ff;
   lrwr_pkg::run_type    prev_run_ff;
   logic [lrwr_pkg::RUN_BITS:0] prev_run_inc;
   logic                 case_start;
   logic [1:0]           in_flight_ff, in_flight_in;

   assign rsp_take     = rsp_valid && !rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign case_start   = !prev_vld_ff || prev_done_ff;
   assign prev_run_inc = {1'b0, prev_run_ff} + (lrwr_pkg::RUN_BITS + 1)'(1);

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_take && !rsp_take) begin
         in_flight_in = in_flight_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         in_flight_in = in_flight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vld_ff  <= 1'b0;
         in_flight_ff <= '0;
      end else begin
         if (rsp_take) begin
            prev_vld_ff <= 1'b1;
         end
         in_flight_ff <= in_flight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         prev_done_ff <= rsp_case_done;
         prev_run_ff  <= rsp_longest_run;
      end
   end

   `LRWR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_longest_run) && $stable(rsp_case_done))

   `LRWR_ASSERT_NOW(a_run_nonzero, clock, reset, rsp_valid, rsp_longest_run != '0)

   `LRWR_ASSERT_NOW(a_case_first, clock, reset, rsp_take && case_start,
      rsp_longest_run == lrwr_pkg::run_type'(1))

   `LRWR_ASSERT_NOW(a_case_grow, clock, reset, rsp_take && !case_start,
      (rsp_longest_run >= prev_run_ff) && ({1'b0, rsp_longest_run} <= prev_run_inc))

   // a result beat always belongs to an input beat still in flight
   `LRWR_ASSERT_NOW(a_rsp_has_beat, clock, reset, rsp_valid, in_flight_ff != 2'd0)

endmodule

bind longest_run_without_repeat lrwr_checker u_lrwr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_longest_run (rsp_longest_run),
   .rsp_case_done   (rsp_case_done)
);
